// File: rtl/core/cds_pkg.sv
`timescale 1ns / 1ps

package cds_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 13;
    localparam int KIND_W  = 3;
    localparam int WDAY_W  = 3;

    localparam logic [KIND_W-1:0] KIND_LOAD      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NEXT_DAY  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PREV_DAY  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NEXT_WEEK = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PREV_WEEK = 3'd4;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 13'd1501;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 13'd4999;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_date;

    // Quotient by 25 for values up to 1249: multiply by 1311 / 2^15.
    function automatic logic [5:0] div25(input logic [10:0] q);
        logic [21:0] p;
        p = 22'(q) * 22'd1311;
        return p[20:15];
    endfunction

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [10:0] q4;
        logic [10:0] q16;
        logic [10:0] b4;
        logic [10:0] b16;
        logic        by100;
        logic        by400;
        q4    = y[12:2];
        q16   = {2'b00, y[12:4]};
        b4    = 11'(div25(q4)) * 11'd25;
        b16   = 11'(div25(q16)) * 11'd25;
        by100 = (y[1:0] == 2'b00) && (b4 == q4);
        by400 = (y[3:0] == 4'b0000) && (b16 == q16);
        return ((y[1:0] == 2'b00) && !by100) || by400;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/core/cds_step.sv
`timescale 1ns / 1ps

module cds_step (
    input  cds_pkg::t_date             i_cur,
    input  logic [cds_pkg::KIND_W-1:0] i_kind,
    input  cds_pkg::t_date             i_load,
    output cds_pkg::t_date             o_next,
    output logic                       o_rej
);
    import cds_pkg::*;

    logic             leap_cur;
    logic             leap_load;
    logic [DAY_W-1:0] len;
    logic [DAY_W-1:0] plen;
    logic [DAY_W-1:0] load_len;
    logic [DAY_W-1:0] stp;
    logic [DAY_W:0]   fwd;
    t_date            cand;
    logic             load_ok;
    logic             rej;

    assign leap_cur  = is_leap(i_cur.year);
    assign leap_load = is_leap(i_load.year);
    assign len       = month_len(i_cur.month, leap_cur);
    assign plen      = month_len(i_cur.month - 4'd1, leap_cur);
    assign load_len  = month_len(i_load.month, leap_load);

    assign stp = ((i_kind == KIND_NEXT_DAY) || (i_kind == KIND_PREV_DAY)) ? 5'd1 : 5'd7;
    assign fwd = {1'b0, i_cur.day} + {1'b0, stp};

    assign load_ok = (i_load.year >= YEAR_MIN) && (i_load.year <= YEAR_MAX) &&
                     (i_load.day != 5'd0) && (i_load.day <= load_len);

    always_comb begin
        cand = i_cur;
        rej  = 1'b0;
        unique case (i_kind)
            KIND_LOAD: begin
                if (load_ok) begin
                    cand = i_load;
                end else begin
                    rej = 1'b1;
                end
            end
            KIND_NEXT_DAY, KIND_NEXT_WEEK: begin
                if (fwd <= {1'b0, len}) begin
                    cand.day = fwd[DAY_W-1:0];
                end else begin
                    cand.day = DAY_W'(fwd - {1'b0, len});
                    if (i_cur.month < 4'd12) begin
                        cand.month = i_cur.month + 4'd1;
                    end else begin
                        cand.month = 4'd1;
                        cand.year  = i_cur.year + 13'd1;
                    end
                end
            end
            KIND_PREV_DAY, KIND_PREV_WEEK: begin
                if (i_cur.day > stp) begin
                    cand.day = i_cur.day - stp;
                end else if (i_cur.month > 4'd1) begin
                    cand.month = i_cur.month - 4'd1;
                    cand.day   = DAY_W'({1'b0, i_cur.day} + {1'b0, plen} - {1'b0, stp});
                end else begin
                    // December of the year before always has 31 days
                    cand.month = 4'd12;
                    cand.year  = i_cur.year - 13'd1;
                    cand.day   = DAY_W'({1'b0, i_cur.day} + 6'd31 - {1'b0, stp});
                end
            end
            default: begin
                cand = i_cur;
            end
        endcase
        if ((cand.year < YEAR_MIN) || (cand.year > YEAR_MAX)) begin
            rej = 1'b1;
        end
    end

    assign o_next = rej ? i_cur : cand;
    assign o_rej  = rej;

endmodule

// File: rtl/core/cds_weekday.sv
`timescale 1ns / 1ps

module cds_weekday (
    input  cds_pkg::t_date             i_date,
    output logic [cds_pkg::WDAY_W-1:0] o_weekday
);
    import cds_pkg::*;

    // 23*m/9 for months 1..12
    function automatic logic [4:0] month_term(input logic [MONTH_W-1:0] m);
        logic [4:0] t;
        unique case (m)
            4'd1:    t = 5'd2;
            4'd2:    t = 5'd5;
            4'd3:    t = 5'd7;
            4'd4:    t = 5'd10;
            4'd5:    t = 5'd12;
            4'd6:    t = 5'd15;
            4'd7:    t = 5'd17;
            4'd8:    t = 5'd20;
            4'd9:    t = 5'd23;
            4'd10:   t = 5'd25;
            4'd11:   t = 5'd28;
            4'd12:   t = 5'd30;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

    logic              early;
    logic [YEAR_W-1:0] yy;
    logic [10:0]       q4;
    logic [5:0]        q100;
    logic [5:0]        q400;
    logic [14:0]       tot;
    logic [5:0]        fold1;
    logic [3:0]        fold2;
    logic [2:0]        a;

    assign early = (i_date.month < 4'd3);
    assign yy    = early ? (i_date.year - 13'd1) : i_date.year;
    assign q4    = yy[12:2];
    assign q100  = div25(q4);
    assign q400  = div25({2'b00, yy[12:4]});

    // Sum stays non-negative for every year in range
    assign tot = 15'(month_term(i_date.month)) + 15'(i_date.day) + 15'(i_date.year)
               + 15'd4 + 15'(q4) + 15'(q400) - 15'(q100)
               - (early ? 15'd0 : 15'd2);

    // Reduce mod 7 by summing octal digits (8 = 1 mod 7)
    assign fold1 = 6'(tot[2:0]) + 6'(tot[5:3]) + 6'(tot[8:6])
                 + 6'(tot[11:9]) + 6'(tot[14:12]);
    assign fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    assign a     = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

    // Move Sunday from 0 to 6
    assign o_weekday = (a == 3'd0) ? 3'd6 : a - 3'd1;

endmodule

// File: rtl/core/calendar_date_stepper_unit.sv
// Path from input transaction to result: input, date and output registers.
// Throughput: one transaction per cycle while the master side accepts; the date register can advance every cycle.
// Backpressure on the master side propagates to o_s_tready through the stage enables.
// Reset (synchronous, i_rst_n low) empties all stages and sets the date to 1 January 2000.
`timescale 1ns / 1ps

module calendar_date_stepper_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // new_day[4:0], new_month[8:5], new_year[21:9], zero
    input  logic [2:0]  i_s_tuser,  // kind[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // out_day[4:0], out_month[8:5], out_year[21:9],
                                    // out_weekday[24:22], zero
    output logic [0:0]  o_m_tuser   // rejected[0]
);
    import cds_pkg::*;

    // Stage enables: a stage advances when it is empty or the next one advances
    logic adv_in;
    logic adv_mid;
    logic adv_out;

    // Input register
    logic              r_in_vld;
    logic [KIND_W-1:0] r_in_kind;
    t_date             r_in_load;

    // Held date and the date stage
    t_date r_cur;
    logic  r_mid_vld;
    t_date r_mid_date;
    logic  r_mid_rej;

    // Output register
    logic              r_out_vld;
    t_date             r_out_date;
    logic [WDAY_W-1:0] r_out_wday;
    logic              r_out_rej;

    t_date             n_cur;
    logic              n_rej;
    logic [WDAY_W-1:0] n_wday;
    t_date             s_load;

    assign adv_out = !r_out_vld || i_m_tready;
    assign adv_mid = !r_mid_vld || adv_out;
    assign adv_in  = !r_in_vld  || adv_mid;

    assign o_s_tready = adv_in;

    assign s_load.day   = i_s_tdata[4:0];
    assign s_load.month = i_s_tdata[8:5];
    assign s_load.year  = i_s_tdata[21:9];

    // Capture the transaction; payload holds while the stage is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (adv_in) begin
            r_in_vld <= i_s_tvalid;
        end
        if (adv_in && i_s_tvalid) begin
            r_in_kind <= i_s_tuser;
            r_in_load <= s_load;
        end
    end

    // Step the held date; a refused step or load keeps the date
    cds_step u_step (
        .i_cur  (r_cur),
        .i_kind (r_in_kind),
        .i_load (r_in_load),
        .o_next (n_cur),
        .o_rej  (n_rej)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_vld   <= 1'b0;
            r_cur.day   <= 5'd1;
            r_cur.month <= 4'd1;
            r_cur.year  <= 13'd2000;
        end else if (adv_mid) begin
            r_mid_vld <= r_in_vld;
            if (r_in_vld) begin
                r_cur <= n_cur;
            end
        end
        if (adv_mid && r_in_vld) begin
            r_mid_date <= n_cur;
            r_mid_rej  <= n_rej;
        end
    end

    // Weekday of the stepped date
    cds_weekday u_weekday (
        .i_date    (r_mid_date),
        .o_weekday (n_wday)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv_out) begin
            r_out_vld <= r_mid_vld;
        end
        if (adv_out && r_mid_vld) begin
            r_out_date <= r_mid_date;
            r_out_wday <= n_wday;
            r_out_rej  <= r_mid_rej;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {7'd0, r_out_wday, r_out_date.year, r_out_date.month, r_out_date.day};
    assign o_m_tuser  = r_out_rej;

endmodule

// File: test/tb_calendar_date_stepper_unit.sv
`timescale 1ns / 1ps

module tb_calendar_date_stepper_unit;
    import cds_pkg::*;

    localparam int NUM_DIRECTED     = 25;
    localparam int RANDOM_PER_PHASE = 425;
    localparam int NUM_PHASES       = 4;
    localparam int DRAIN_CYCLES     = 12;
    localparam int WATCHDOG_LIMIT   = 1000;

    // Kinds the block ignores: the date is shown unchanged and nothing is refused.
    localparam logic [KIND_W-1:0] KIND_SPARE_5 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [WDAY_W-1:0]  wday;
        logic               rej;
    } t_date_result;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               typed;
        logic [DAY_W-1:0]   exp_day;
        logic [MONTH_W-1:0] exp_month;
        logic [YEAR_W-1:0]  exp_year;
        logic               exp_rej;
    } t_stim_row;

    // Rows with typed set carry the expected date and refusal flag; the rest are predicted.
    localparam t_stim_row DIRECTED [NUM_DIRECTED] = '{
        '{KIND_SPARE_7,   5'd31, 4'd15, 13'd8191, 1'b1, 5'd1,  4'd1,  13'd2000, 1'b0},
        '{KIND_SPARE_5,   5'd0,  4'd0,  13'd0,    1'b1, 5'd1,  4'd1,  13'd2000, 1'b0},
        '{KIND_SPARE_6,   5'd17, 4'd9,  13'd4242, 1'b1, 5'd1,  4'd1,  13'd2000, 1'b0},
        '{KIND_PREV_DAY,  5'd0,  4'd0,  13'd0,    1'b0, 5'd0,  4'd0,  13'd0,    1'b0},
        '{KIND_NEXT_DAY,  5'd0,  4'd0,  13'd0,    1'b0, 5'd0,  4'd0,  13'd0,    1'b0},
        '{KIND_LOAD,      5'd0,  4'd0,  13'd0,    1'b1, 5'd1,  4'd1,  13'd2000, 1'b1},
        '{KIND_LOAD,      5'd1,  4'd1,  13'd1500, 1'b1, 5'd1,  4'd1,  13'd2000, 1'b1},
        '{KIND_LOAD,      5'd1,  4'd1,  13'd5000, 1'b1, 5'd1,  4'd1,  13'd2000, 1'b1},
        '{KIND_LOAD,      5'd1,  4'd1,  13'd8191, 1'b1, 5'd1,  4'd1,  13'd2000, 1'b1},
        '{KIND_LOAD,      5'd29, 4'd2,  13'd1900, 1'b1, 5'd1,  4'd1,  13'd2000, 1'b1},
        '{KIND_LOAD,      5'd31, 4'd4,  13'd2001, 1'b1, 5'd1,  4'd1,  13'd2000, 1'b1},
        '{KIND_LOAD,      5'd1,  4'd13, 13'd2001, 1'b1, 5'd1,  4'd1,  13'd2000, 1'b1},
        '{KIND_LOAD,      5'd1,  4'd0,  13'd2001, 1'b1, 5'd1,  4'd1,  13'd2000, 1'b1},
        '{KIND_LOAD,      5'd29, 4'd2,  13'd2000, 1'b0, 5'd0,  4'd0,  13'd0,    1'b0},
        '{KIND_NEXT_DAY,  5'd0,  4'd0,  13'd0,    1'b0, 5'd0,  4'd0,  13'd0,    1'b0},
        '{KIND_PREV_WEEK, 5'd0,  4'd0,  13'd0,    1'b0, 5'd0,  4'd0,  13'd0,    1'b0},
        '{KIND_NEXT_WEEK, 5'd0,  4'd0,  13'd0,    1'b0, 5'd0,  4'd0,  13'd0,    1'b0},
        '{KIND_LOAD,      5'd1,  4'd1,  13'd1501, 1'b1, 5'd1,  4'd1,  13'd1501, 1'b0},
        '{KIND_PREV_DAY,  5'd0,  4'd0,  13'd0,    1'b1, 5'd1,  4'd1,  13'd1501, 1'b1},
        '{KIND_PREV_WEEK, 5'd0,  4'd0,  13'd0,    1'b1, 5'd1,  4'd1,  13'd1501, 1'b1},
        '{KIND_LOAD,      5'd31, 4'd12, 13'd4999, 1'b1, 5'd31, 4'd12, 13'd4999, 1'b0},
        '{KIND_NEXT_DAY,  5'd0,  4'd0,  13'd0,    1'b1, 5'd31, 4'd12, 13'd4999, 1'b1},
        '{KIND_NEXT_WEEK, 5'd0,  4'd0,  13'd0,    1'b1, 5'd31, 4'd12, 13'd4999, 1'b1},
        '{KIND_LOAD,      5'd1,  4'd3,  13'd2100, 1'b0, 5'd0,  4'd0,  13'd0,    1'b0},
        '{KIND_PREV_DAY,  5'd0,  4'd0,  13'd0,    1'b0, 5'd0,  4'd0,  13'd0,    1'b0}
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata  = '0;
    logic [2:0]  i_s_tuser  = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic [0:0]  o_m_tuser;

    // Typed expectation travelling alongside the transaction on the slave side.
    logic         row_typed  = 1'b0;
    t_date_result row_expect = '0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    // Predictor state: the date the block should be holding.
    int held_day   = 1;
    int held_month = 1;
    int held_year  = 2000;

    t_date_result pending_dates[$];
    int           mismatch_count = 0;
    int           quiet_cycles   = 0;

    calendar_date_stepper_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit year_is_leap(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_days(input int m, input int y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return year_is_leap(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Congruence gives Sunday as 0; rotate so Monday is 0.
    function automatic int weekday_of(input int d, input int m, input int y);
        int s;
        int yy;
        int a;
        if (m < 3) begin
            s  = d + y;
            yy = y - 1;
        end else begin
            s  = d + y - 2;
            yy = y;
        end
        a = (23 * m / 9 + s + 4 + yy / 4 + yy / 400 - yy / 100) % 7;
        return (a == 0) ? 6 : a - 1;
    endfunction

    function automatic t_date_result advance_calendar(input logic [KIND_W-1:0] kind,
                                                      input logic [21:0] fields);
        int           nd;
        int           nm;
        int           ny;
        int           d;
        int           m;
        int           y;
        int           len;
        int           stride;
        bit           rej;
        t_date_result r;
        nd  = int'(fields[4:0]);
        nm  = int'(fields[8:5]);
        ny  = int'(fields[21:9]);
        d   = held_day;
        m   = held_month;
        y   = held_year;
        len = month_days(m, y);
        rej = 1'b0;
        case (kind)
            KIND_LOAD: begin
                if (ny < int'(YEAR_MIN) || ny > int'(YEAR_MAX) || nm < 1 || nm > 12 ||
                    nd < 1 || nd > month_days(nm, ny)) begin
                    rej = 1'b1;
                end else begin
                    d = nd;
                    m = nm;
                    y = ny;
                end
            end
            KIND_NEXT_DAY, KIND_NEXT_WEEK: begin
                stride = (kind == KIND_NEXT_DAY) ? 1 : 7;
                if (d + stride <= len) begin
                    d = d + stride;
                end else begin
                    d = d + stride - len;
                    if (m < 12) begin
                        m = m + 1;
                    end else begin
                        m = 1;
                        y = y + 1;
                    end
                end
            end
            KIND_PREV_DAY, KIND_PREV_WEEK: begin
                stride = (kind == KIND_PREV_DAY) ? 1 : 7;
                if (d > stride) begin
                    d = d - stride;
                end else if (m > 1) begin
                    m = m - 1;
                    d = d + month_days(m, y) - stride;
                end else begin
                    // December of the year before always has 31 days
                    m = 12;
                    y = y - 1;
                    d = d + 31 - stride;
                end
            end
            default: ;
        endcase
        if (y < int'(YEAR_MIN) || y > int'(YEAR_MAX)) rej = 1'b1;
        if (!rej) begin
            held_day   = d;
            held_month = m;
            held_year  = y;
        end
        r.day   = DAY_W'(held_day);
        r.month = MONTH_W'(held_month);
        r.year  = YEAR_W'(held_year);
        r.wday  = WDAY_W'(weekday_of(held_day, held_month, held_year));
        r.rej   = rej;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Hold the transaction until it is taken; idle beforehand as the phase dictates.
    task automatic send_txn(input logic [KIND_W-1:0] kind, input logic [21:0] fields,
                            input logic typed, input t_date_result typed_r);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {2'b00, fields};
        row_typed  <= typed;
        row_expect <= typed_r;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_date_result want_r;
        t_date_result seen_r;
        t_date_result got_r;
        bit           moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_s_tvalid && o_s_tready) begin
                moved  = 1'b1;
                want_r = advance_calendar(i_s_tuser, i_s_tdata[21:0]);
                // Weekday always comes from the predictor.
                if (row_typed) begin
                    want_r.day   = row_expect.day;
                    want_r.month = row_expect.month;
                    want_r.year  = row_expect.year;
                    want_r.rej   = row_expect.rej;
                end
                pending_dates.push_back(want_r);
            end
            if (o_m_tvalid && i_m_tready) begin
                moved       = 1'b1;
                got_r.day   = o_m_tdata[4:0];
                got_r.month = o_m_tdata[8:5];
                got_r.year  = o_m_tdata[21:9];
                got_r.wday  = o_m_tdata[24:22];
                got_r.rej   = o_m_tuser[0];
                if (pending_dates.size() == 0) begin
                    report_mismatch("result with nothing pending, day", got_r.day, 0);
                end else begin
                    seen_r = pending_dates.pop_front();
                    if (got_r.day !== seen_r.day)
                        report_mismatch("day", got_r.day, seen_r.day);
                    if (got_r.month !== seen_r.month)
                        report_mismatch("month", got_r.month, seen_r.month);
                    if (got_r.year !== seen_r.year)
                        report_mismatch("year", got_r.year, seen_r.year);
                    if (got_r.wday !== seen_r.wday)
                        report_mismatch("weekday", got_r.wday, seen_r.wday);
                    if (got_r.rej !== seen_r.rej)
                        report_mismatch("rejected", got_r.rej, seen_r.rej);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int                 phase;
        int                 pick;
        int                 yr;
        int                 mo;
        int                 dy;
        int                 len;
        logic [KIND_W-1:0]  kind;
        logic [21:0]        fields;
        t_date_result       typed_r;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 71; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 71; end
                default: begin src_idle_pct = 38; sink_stall_pct = 38; end
            endcase

            if (phase == 0) begin
                for (int i = 0; i < NUM_DIRECTED; i++) begin
                    typed_r       = '0;
                    typed_r.day   = DIRECTED[i].exp_day;
                    typed_r.month = DIRECTED[i].exp_month;
                    typed_r.year  = DIRECTED[i].exp_year;
                    typed_r.rej   = DIRECTED[i].exp_rej;
                    send_txn(DIRECTED[i].kind,
                             {DIRECTED[i].year, DIRECTED[i].month, DIRECTED[i].day},
                             DIRECTED[i].typed, typed_r);
                end
            end

            repeat (RANDOM_PER_PHASE) begin
                pick   = $urandom_range(99);
                fields = 22'($urandom);
                if (pick < 12) begin
                    // Legal load, often close to the ends of the year range or on a century year.
                    case ($urandom_range(3))
                        0: begin
                            yr = $urandom_range(1501, 1503);
                            mo = $urandom_range(1, 2);
                        end
                        1: begin
                            yr = $urandom_range(4997, 4999);
                            mo = $urandom_range(11, 12);
                        end
                        2: begin
                            yr = 100 * $urandom_range(16, 49);
                            mo = $urandom_range(1, 12);
                        end
                        default: begin
                            yr = $urandom_range(1501, 4999);
                            mo = $urandom_range(1, 12);
                        end
                    endcase
                    len = month_days(mo, yr);
                    if ($urandom_range(1)) dy = $urandom_range(1, 7);
                    else                   dy = len - $urandom_range(0, 6);
                    kind   = KIND_LOAD;
                    fields = {YEAR_W'(yr), MONTH_W'(mo), DAY_W'(dy)};
                end else if (pick < 17) begin
                    kind = KIND_LOAD;
                end else if (pick < 21) begin
                    kind = 3'($urandom_range(KIND_SPARE_5, KIND_SPARE_7));
                end else begin
                    kind = 3'($urandom_range(KIND_NEXT_DAY, KIND_PREV_WEEK));
                end
                send_txn(kind, fields, 1'b0, '0);
            end
        end

        i_s_tvalid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_dates.size() != 0)
            report_mismatch("results never delivered", 0, pending_dates.size());

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
